FILE: rtl/scrc_pkg.sv
// ----------------------------------------------------------------------------
// scrc_pkg
// Shared types, constants and the sRGB linearization table builder for the
// sRGB contrast ratio checker.
// ----------------------------------------------------------------------------
package scrc_pkg;

  // Field widths
  localparam int unsigned CH_W       = 8;    // one sRGB channel or alpha
  localparam int unsigned MIN_W      = 24;   // minimum ratio register, Q8.16
  localparam int unsigned RATIO_W    = 21;   // ratio result, Q5.16
  localparam int unsigned RATIO_FRAC = 16;   // fraction bits of the ratio
  localparam int unsigned RATIO_INT  = RATIO_W - RATIO_FRAC;

  // Luminance is scaled by 10000, so it needs 14 bits above the fraction
  localparam int unsigned LUMA_HEAD  = 14;

  // Luminance weights in units of 1/10000
  localparam int unsigned W_RED      = 2126;
  localparam int unsigned W_GREEN    = 7152;
  localparam int unsigned W_BLUE     = 722;

  // 0.05 offset in the same 1/10000 units
  localparam int unsigned LUMA_BIAS  = 500;

  localparam logic [CH_W-1:0]    ALPHA_OPAQUE = 8'hFF;
  localparam logic [MIN_W-1:0]   MIN_RESET    = 24'd294912;   // 4.5
  localparam logic [RATIO_W-1:0] RATIO_ONE    = 21'd65536;    // 1.0
  localparam logic [RATIO_W-1:0] RATIO_MAX    = 21'd1376256;  // 21.0

  // Linearization table: 256 entries, each held in 32 bits
  localparam int unsigned TAB_W   = 32;
  localparam int unsigned TAB_LEN = 256;
  typedef logic [TAB_LEN-1:0][TAB_W-1:0] lin_tab_t;

  // x^5 in Q2.30, each product truncated
  function automatic logic [63:0] fifth_pow_q30(logic [63:0] x);
    logic [63:0] p;
    p = x;
    for (int i = 0; i < 4; i++) begin
      p = (p * x) >> 30;
    end
    return p;
  endfunction

  // One entry of the sRGB-to-linear curve, rounded to Q1.frac
  function automatic logic [TAB_W-1:0] curve_entry(int unsigned c, int unsigned frac);
    logic [63:0] cc;
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] y;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    cc = 64'(c);
    // linear segment near black
    if (cc * 64'd100000 <= 64'd1031475) begin
      return TAB_W'((cc * 64'd10 * (64'd1 << frac) + 64'd16473) / 64'd32946);
    end
    // ((c/255 + 0.055)/1.055)^2.4 as t^2 * (t^2)^(1/5)
    t  = ((cc * 64'd1000 + 64'd14025) << 30) / 64'd269025;
    u  = (t * t) >> 30;
    lo = 64'd0;
    hi = 64'd1 << 30;
    for (int k = 0; k < 32; k++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (fifth_pow_q30(mid) <= u) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    y = (u * lo) >> 30;
    return TAB_W'((y + (64'd1 << (29 - frac))) >> (30 - frac));
  endfunction

  // Whole table, worked out at elaboration
  function automatic lin_tab_t build_lin_tab(int unsigned frac);
    lin_tab_t tab;
    for (int unsigned c = 0; c < TAB_LEN; c++) begin
      tab[c] = curve_entry(c, frac);
    end
    return tab;
  endfunction

endpackage

FILE: rtl/srgb_contrast_ratio_check.sv
// ----------------------------------------------------------------------------
// srgb_contrast_ratio_check
// Contrast ratio of two opaque 8-bit sRGB colours, (L1+0.05)/(L2+0.05) in
// Q5.16, with a pass flag against a programmable minimum.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake              | Payload
//  --------+------------------------+-----------------------------------------
//  input   | in_valid / in_ready    | first_*, second_* (red, green, blue, alpha)
//  output  | out_valid / out_ready  | ok, ratio_q16, meets
//  config  | cfg_we (no wait)       | cfg_wdata -> minimum ratio, Q8.16
//
//  Throughput is one transaction per cycle while out_ready keeps the output
//  draining. The depth is set by the restoring divider, which resolves one
//  quotient bit per stage over 21 stages, behind four stages of table lookup,
//  weighting, summing and ordering, and ahead of the output register.
//  Reset clears all stage valid bits and loads the minimum with 4.5.
//  A stage holds when it is full and the next one cannot take its data, so
//  bubbles are squeezed out and in_ready stays high while any stage is empty.
//
module srgb_contrast_ratio_check #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,

  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [scrc_pkg::CH_W-1:0]    first_red,
  input  logic [scrc_pkg::CH_W-1:0]    first_green,
  input  logic [scrc_pkg::CH_W-1:0]    first_blue,
  input  logic [scrc_pkg::CH_W-1:0]    first_alpha,
  input  logic [scrc_pkg::CH_W-1:0]    second_red,
  input  logic [scrc_pkg::CH_W-1:0]    second_green,
  input  logic [scrc_pkg::CH_W-1:0]    second_blue,
  input  logic [scrc_pkg::CH_W-1:0]    second_alpha,

  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         ok,
  output logic [scrc_pkg::RATIO_W-1:0] ratio_q16,
  output logic                         meets,

  input  logic                         cfg_we,
  input  logic [scrc_pkg::MIN_W-1:0]   cfg_wdata
);

  import scrc_pkg::*;

  localparam int unsigned LIN_W     = FRAC_BITS + 1;
  localparam int unsigned LUMA_W    = FRAC_BITS + LUMA_HEAD;
  localparam int unsigned DIV_STEPS = RATIO_W;

  // Stage numbering
  localparam int unsigned ST_LIN  = 0;
  localparam int unsigned ST_MUL  = 1;
  localparam int unsigned ST_SUM  = 2;
  localparam int unsigned ST_ORD  = 3;
  localparam int unsigned ST_OUT  = ST_ORD + DIV_STEPS + 1;
  localparam int unsigned NST     = ST_OUT + 1;

  localparam lin_tab_t          LIN_TAB = build_lin_tab(FRAC_BITS);
  localparam logic [LUMA_W-1:0] BIAS    = LUMA_W'(LUMA_BIAS) << FRAC_BITS;

  // Configuration register
  logic [MIN_W-1:0] minimum_ratio_q16;

  always_ff @(posedge clk) begin
    if (rst) begin
      minimum_ratio_q16 <= MIN_RESET;
    end else if (cfg_we) begin
      minimum_ratio_q16 <= cfg_wdata;
    end
  end

  // Stage valid bits and per-stage load enables
  logic [NST-1:0] vld;
  logic [NST-1:0] en;
  logic [NST-1:0] vld_in;

  assign en[NST-1] = !vld[NST-1] || out_ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  assign vld_in = {vld[NST-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  assign in_ready  = en[ST_LIN];
  assign out_valid = vld[ST_OUT];

  // Stage 0: opacity check and table lookup
  logic             lin_ok;
  logic [LIN_W-1:0] lin1_r;
  logic [LIN_W-1:0] lin1_g;
  logic [LIN_W-1:0] lin1_b;
  logic [LIN_W-1:0] lin2_r;
  logic [LIN_W-1:0] lin2_g;
  logic [LIN_W-1:0] lin2_b;

  always_ff @(posedge clk) begin
    if (en[ST_LIN]) begin
      lin_ok <= (first_alpha == ALPHA_OPAQUE) && (second_alpha == ALPHA_OPAQUE);
      lin1_r <= LIN_TAB[first_red][LIN_W-1:0];
      lin1_g <= LIN_TAB[first_green][LIN_W-1:0];
      lin1_b <= LIN_TAB[first_blue][LIN_W-1:0];
      lin2_r <= LIN_TAB[second_red][LIN_W-1:0];
      lin2_g <= LIN_TAB[second_green][LIN_W-1:0];
      lin2_b <= LIN_TAB[second_blue][LIN_W-1:0];
    end
  end

  // Stage 1: channel weights
  logic              mul_ok;
  logic [LUMA_W-1:0] p1_r;
  logic [LUMA_W-1:0] p1_g;
  logic [LUMA_W-1:0] p1_b;
  logic [LUMA_W-1:0] p2_r;
  logic [LUMA_W-1:0] p2_g;
  logic [LUMA_W-1:0] p2_b;

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      mul_ok <= lin_ok;
      p1_r   <= LUMA_W'(W_RED)   * LUMA_W'(lin1_r);
      p1_g   <= LUMA_W'(W_GREEN) * LUMA_W'(lin1_g);
      p1_b   <= LUMA_W'(W_BLUE)  * LUMA_W'(lin1_b);
      p2_r   <= LUMA_W'(W_RED)   * LUMA_W'(lin2_r);
      p2_g   <= LUMA_W'(W_GREEN) * LUMA_W'(lin2_g);
      p2_b   <= LUMA_W'(W_BLUE)  * LUMA_W'(lin2_b);
    end
  end

  // Stage 2: luminance sums, scaled by 10000
  logic              sum_ok;
  logic [LUMA_W-1:0] luma1;
  logic [LUMA_W-1:0] luma2;

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      sum_ok <= mul_ok;
      luma1  <= p1_r + p1_g + p1_b;
      luma2  <= p2_r + p2_g + p2_b;
    end
  end

  // Stage 3: order, add offset and seed the divider.
  // Dividend is (hi + bias) << 16; its upper part stays below the divisor,
  // so the remainder starts with it and the low bits shift in one per step.
  logic                 first_hi;
  logic [LUMA_W-1:0]    num_ord;
  logic [LUMA_W-1:0]    den_ord;

  assign first_hi = luma1 > luma2;
  assign num_ord  = (first_hi ? luma1 : luma2) + BIAS;
  assign den_ord  = (first_hi ? luma2 : luma1) + BIAS;

  logic                 d_ok  [DIV_STEPS+1];
  logic [LUMA_W-1:0]    d_rem [DIV_STEPS+1];
  logic [LUMA_W-1:0]    d_den [DIV_STEPS+1];
  logic [RATIO_W-1:0]   d_sh  [DIV_STEPS+1];
  logic [RATIO_W-1:0]   d_quo [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (en[ST_ORD]) begin
      d_ok[0]  <= sum_ok;
      d_rem[0] <= num_ord >> RATIO_INT;
      d_den[0] <= den_ord;
      d_sh[0]  <= RATIO_W'(num_ord[RATIO_INT-1:0]) << RATIO_FRAC;
      d_quo[0] <= '0;
    end
  end

  // Restoring divider, one quotient bit per stage
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
    logic [LUMA_W:0] trial;
    logic [LUMA_W:0] diff;
    logic            take;

    assign trial = {d_rem[j-1], d_sh[j-1][RATIO_W-1]};
    assign diff  = trial - {1'b0, d_den[j-1]};
    assign take  = trial >= {1'b0, d_den[j-1]};

    always_ff @(posedge clk) begin
      if (en[ST_ORD + j]) begin
        d_ok[j]  <= d_ok[j-1];
        d_rem[j] <= take ? diff[LUMA_W-1:0] : trial[LUMA_W-1:0];
        d_den[j] <= d_den[j-1];
        d_sh[j]  <= d_sh[j-1] << 1;
        d_quo[j] <= {d_quo[j-1][RATIO_W-2:0], take};
      end
    end
  end

  // Output register: gate by opacity, compare with the minimum
  logic [RATIO_W-1:0] quo_fin;
  assign quo_fin = d_quo[DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      ok        <= d_ok[DIV_STEPS];
      ratio_q16 <= d_ok[DIV_STEPS] ? quo_fin : '0;
      meets     <= d_ok[DIV_STEPS] && (minimum_ratio_q16 != '0)
                   && (MIN_W'(quo_fin) >= minimum_ratio_q16);
    end
  end

endmodule

FILE: rtl/scrc_checker.sv
// ----------------------------------------------------------------------------
// scrc_checker
// Port-level checks for the sRGB contrast ratio checker, bound to the top.
// ----------------------------------------------------------------------------
module scrc_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic                         ok,
  input  logic [scrc_pkg::RATIO_W-1:0] ratio_q16,
  input  logic                         meets
);

  import scrc_pkg::*;

  // Nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  // A free output side always leaves room for a new transaction
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    (out_ready || !out_valid) |-> in_ready)
    else $error("in_ready low while the output side can drain");

  // Non-opaque pairs give an all-zero result
  a_not_ok_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !ok) |-> (ratio_q16 == '0) && !meets)
    else $error("result fields nonzero without ok");

  // A valid ratio lies between 1.0 and 21.0
  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && ok) |-> (ratio_q16 >= RATIO_ONE) && (ratio_q16 <= RATIO_MAX))
    else $error("ratio outside 1.0 .. 21.0");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(ratio_q16) && $stable(ok)
                                  && $stable(meets))
    else $error("stalled result changed");

endmodule

bind srgb_contrast_ratio_check scrc_checker u_scrc_checker (.*);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for srgb_contrast_ratio_check. Colour pairs are
// streamed in bursts while the result channel stalls on its own pattern. An
// in-bench scoreboard builds its own sRGB linearization curve, predicts
// ok/ratio/meets for every accepted transaction and checks results in order.
// The minimum ratio register is swept between phases, extremes included.
// ---------------------------------------------------------------------------
module tb_top;
  import scrc_pkg::*;

  localparam int unsigned     LIN_FRAC         = 16;
  localparam logic [CH_W-1:0] OPAQUE           = 8'hFF;
  localparam logic [MIN_W-1:0] MIN_AT_RESET    = 24'd294912;  // 4.5
  localparam longint unsigned Q30_ONE          = 64'd1 << 30;
  localparam longint unsigned WT_RED           = 2126;
  localparam longint unsigned WT_GREEN         = 7152;
  localparam longint unsigned WT_BLUE          = 722;
  localparam longint unsigned LUMA_OFFSET      = 64'd500 << LIN_FRAC;
  localparam int unsigned     QUOT_FRAC        = 16;
  localparam int unsigned     HOLD_CYCLES      = 120;
  localparam int unsigned     RANDOM_PER_PHASE = 90;
  localparam int unsigned     NUM_PHASES       = 10;
  localparam int unsigned     SETTLE_CYCLES    = 40;

  typedef struct packed {
    logic [CH_W-1:0] r1;
    logic [CH_W-1:0] g1;
    logic [CH_W-1:0] b1;
    logic [CH_W-1:0] a1;
    logic [CH_W-1:0] r2;
    logic [CH_W-1:0] g2;
    logic [CH_W-1:0] b2;
    logic [CH_W-1:0] a2;
  } pair_t;

  typedef struct packed {
    logic               ok;
    logic [RATIO_W-1:0] ratio;
    logic               meets;
  } verdict_t;

  // Scoreboard: own sRGB curve, own copy of the minimum, in-order verdicts
  class contrast_scoreboard;
    logic [31:0]      lin_curve [256];
    logic [MIN_W-1:0] min_ratio;
    verdict_t         awaited_verdicts [$];
    int               fail_count;

    function new();
      for (int c = 0; c < 256; c++) begin
        lin_curve[c] = code_to_light(c);
      end
      min_ratio  = MIN_AT_RESET;
      fail_count = 0;
    endfunction

    // x^5 in Q2.30 with every product truncated
    function longint unsigned pow5_q30(longint unsigned x);
      longint unsigned p;
      p = x;
      repeat (4) p = (p * x) >> 30;
      return p;
    endfunction

    // sRGB code to linear light, Q1.16 rounded
    function logic [31:0] code_to_light(int unsigned c);
      longint unsigned code;
      longint unsigned t;
      longint unsigned u;
      longint unsigned root;
      longint unsigned cand;
      longint unsigned y;
      code = c;
      // linear toe near black
      if (code * 100000 <= 1031475) begin
        return 32'((code * 655360 + 16473) / 32946);
      end
      t = ((code * 1000 + 14025) << 30) / 269025;
      u = (t * t) >> 30;
      // largest root in [0, 1.0] whose truncated fifth power stays <= u
      root = 0;
      for (int b = 30; b >= 0; b--) begin
        cand = root | (64'd1 << b);
        if (cand <= Q30_ONE && pow5_q30(cand) <= u) root = cand;
      end
      y = (u * root) >> 30;
      return 32'((y + (64'd1 << (29 - LIN_FRAC))) >> (30 - LIN_FRAC));
    endfunction

    function longint unsigned luma(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                   logic [CH_W-1:0] b);
      return WT_RED * lin_curve[r] + WT_GREEN * lin_curve[g] + WT_BLUE * lin_curve[b];
    endfunction

    // Expected result for one colour pair under the current minimum
    function verdict_t wcag_verdict(pair_t p);
      verdict_t        v;
      longint unsigned l1;
      longint unsigned l2;
      longint unsigned bright;
      longint unsigned dark;
      longint unsigned q;
      v = '0;
      if (p.a1 != OPAQUE || p.a2 != OPAQUE) return v;
      l1     = luma(p.r1, p.g1, p.b1);
      l2     = luma(p.r2, p.g2, p.b2);
      bright = (l1 > l2) ? l1 : l2;
      dark   = (l1 > l2) ? l2 : l1;
      q      = ((bright + LUMA_OFFSET) << QUOT_FRAC) / (dark + LUMA_OFFSET);
      v.ok    = 1'b1;
      v.ratio = q[RATIO_W-1:0];
      v.meets = (min_ratio != 0) && (32'(v.ratio) >= 32'(min_ratio));
      return v;
    endfunction

    function void note_pair(pair_t p);
      awaited_verdicts.push_back(wcag_verdict(p));
    endfunction

    function int pending();
      return awaited_verdicts.size();
    endfunction

    task report(string msg);
      $display("%0t ERROR: %s", $time, msg);
      fail_count++;
    endtask

    task check_verdict(logic got_ok, logic [RATIO_W-1:0] got_ratio, logic got_meets);
      verdict_t want;
      if (awaited_verdicts.size() == 0) begin
        report($sformatf("result with none pending: ok=%0d ratio=%0d meets=%0d",
                         got_ok, got_ratio, got_meets));
        return;
      end
      want = awaited_verdicts.pop_front();
      if (got_ok !== want.ok)
        report($sformatf("ok mismatch: got %0d, want %0d", got_ok, want.ok));
      if (got_ratio !== want.ratio)
        report($sformatf("ratio_q16 mismatch: got %0d, want %0d", got_ratio, want.ratio));
      if (got_meets !== want.meets)
        report($sformatf("meets mismatch: got %0d, want %0d (ratio %0d, min %0d)",
                         got_meets, want.meets, want.ratio, min_ratio));
    endtask
  endclass

  // DUT signals; the inputs are all known from time zero
  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [CH_W-1:0]    first_red    = '0;
  logic [CH_W-1:0]    first_green  = '0;
  logic [CH_W-1:0]    first_blue   = '0;
  logic [CH_W-1:0]    first_alpha  = '0;
  logic [CH_W-1:0]    second_red   = '0;
  logic [CH_W-1:0]    second_green = '0;
  logic [CH_W-1:0]    second_blue  = '0;
  logic [CH_W-1:0]    second_alpha = '0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic               ok;
  logic [RATIO_W-1:0] ratio_q16;
  logic               meets;
  logic               cfg_we       = 1'b0;
  logic [MIN_W-1:0]   cfg_wdata    = '0;

  contrast_scoreboard sb;
  int                 burst_left    = 0;
  bit                 long_hold_req = 1'b0;

  srgb_contrast_ratio_check #(.FRAC_BITS(LIN_FRAC)) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .first_red    (first_red),
    .first_green  (first_green),
    .first_blue   (first_blue),
    .first_alpha  (first_alpha),
    .second_red   (second_red),
    .second_green (second_green),
    .second_blue  (second_blue),
    .second_alpha (second_alpha),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .ok           (ok),
    .ratio_q16    (ratio_q16),
    .meets        (meets),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Run limit
  initial begin
    #800000;
    $display("Test completed with failures");
    $finish;
  end

  // Result monitor: check every accepted output transaction
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) begin
      sb.check_verdict(ok, ratio_q16, meets);
    end
  end

  // Result side stalls: random modes, a rotating pattern, and long holds on request
  initial begin : rx_stall
    int         mode;
    int         span;
    logic [7:0] pattern;
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_ready <= 1'b0;
        end
      end
      mode    = $urandom_range(0, 3);
      span    = $urandom_range(8, 60);
      pattern = 8'($urandom);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: begin
            out_ready <= pattern[0];
            pattern = {pattern[0], pattern[7:1]};
          end
        endcase
      end
    end
  end

  function automatic pair_t colour_pair(
    logic [CH_W-1:0] r1, logic [CH_W-1:0] g1, logic [CH_W-1:0] b1, logic [CH_W-1:0] a1,
    logic [CH_W-1:0] r2, logic [CH_W-1:0] g2, logic [CH_W-1:0] b2, logic [CH_W-1:0] a2);
    return {r1, g1, b1, a1, r2, g2, b2, a2};
  endfunction

  // Random pair: mostly opaque with varied structure, some noise and broken alpha
  function automatic pair_t random_pair();
    pair_t p;
    int    kind;
    p    = pair_t'({$urandom, $urandom});
    p.a1 = OPAQUE;
    p.a2 = OPAQUE;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      p.a1 = CH_W'($urandom);
      p.a2 = CH_W'($urandom);
    end else if (kind < 14) begin
      if ($urandom_range(0, 1)) p.a1 = CH_W'($urandom_range(0, 254));
      else                      p.a2 = CH_W'($urandom_range(0, 254));
    end else if (kind < 24) begin
      {p.r2, p.g2, p.b2} = {p.r1, p.g1, p.b1};
    end else if (kind < 34) begin
      {p.g1, p.b1} = {p.r1, p.r1};
      {p.g2, p.b2} = {p.r2, p.r2};
    end else if (kind < 42) begin
      // nearly equal colours
      p.r2 = p.r1 ^ 8'($urandom_range(0, 3));
      p.g2 = p.g1 ^ 8'($urandom_range(0, 3));
      p.b2 = p.b1 ^ 8'($urandom_range(0, 3));
    end else if (kind < 48) begin
      // codes around the linear toe
      p.r1 = CH_W'($urandom_range(0, 12));
      p.g1 = CH_W'($urandom_range(0, 12));
      p.b1 = CH_W'($urandom_range(0, 12));
    end
    return p;
  endfunction

  // Offer one pair, with burst/gap shaping, and wait for acceptance
  task automatic send_pair(input pair_t p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    first_red    <= p.r1;
    first_green  <= p.g1;
    first_blue   <= p.b1;
    first_alpha  <= p.a1;
    second_red   <= p.r2;
    second_green <= p.g2;
    second_blue  <= p.b2;
    second_alpha <= p.a2;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_pair(p);
  endtask

  // Stop offering and wait for every pending result
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_minimum(input logic [MIN_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.min_ratio = value;
  endtask

  // Main sequence
  initial begin : stimulus
    pair_t            lead;
    verdict_t         tie;
    logic [MIN_W-1:0] minimum;
    sb = new();
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // Directed pairs under the reset minimum
    send_pair(colour_pair(0, 0, 0, OPAQUE, 255, 255, 255, OPAQUE));
    send_pair(colour_pair(255, 255, 255, OPAQUE, 0, 0, 0, OPAQUE));
    send_pair(colour_pair(255, 255, 255, OPAQUE, 255, 255, 255, OPAQUE));
    send_pair(colour_pair(0, 0, 0, OPAQUE, 0, 0, 0, OPAQUE));
    send_pair(colour_pair(128, 128, 128, OPAQUE, 128, 128, 128, OPAQUE));
    send_pair(colour_pair(255, 0, 0, OPAQUE, 0, 0, 0, OPAQUE));
    send_pair(colour_pair(0, 255, 0, OPAQUE, 0, 0, 0, OPAQUE));
    send_pair(colour_pair(0, 0, 0, OPAQUE, 0, 0, 255, OPAQUE));
    send_pair(colour_pair(10, 10, 10, OPAQUE, 11, 11, 11, OPAQUE));
    send_pair(colour_pair(1, 1, 1, OPAQUE, 0, 0, 0, OPAQUE));
    send_pair(colour_pair(255, 255, 255, 254, 0, 0, 0, OPAQUE));
    send_pair(colour_pair(255, 255, 255, OPAQUE, 0, 0, 0, 254));
    send_pair(colour_pair(255, 255, 255, 0, 255, 255, 255, 0));
    send_pair(colour_pair(0, 0, 0, OPAQUE, 0, 0, 0, 0));
    send_pair(colour_pair(170, 85, 51, 8'h7F, 204, 15, 240, 8'h80));
    send_pair(colour_pair(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(colour_pair(255, 255, 0, OPAQUE, 0, 0, 255, OPAQUE));
    send_pair(colour_pair(119, 119, 119, OPAQUE, 255, 255, 255, OPAQUE));
    send_pair(colour_pair(118, 118, 118, OPAQUE, 255, 255, 255, OPAQUE));
    send_pair(colour_pair(117, 117, 117, OPAQUE, 255, 255, 255, OPAQUE));
    drain();

    // Phases over the minimum register, each led by a pair chosen for it
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      lead = colour_pair(255, 255, 255, OPAQUE, 0, 0, 0, OPAQUE);
      case (ph)
        0:       minimum = '0;
        1:       minimum = '1;
        2:       minimum = 24'd1;
        3:       minimum = MIN_W'(RATIO_ONE);
        4:       minimum = MIN_W'(RATIO_MAX);
        5:       minimum = MIN_W'(RATIO_MAX) + 24'd1;
        6, 7:    minimum = MIN_W'($urandom_range(65536, 1376256));
        8: begin
          // threshold equal to the lead pair's own ratio
          lead    = random_pair();
          lead.a1 = OPAQUE;
          lead.a2 = OPAQUE;
          tie     = sb.wcag_verdict(lead);
          minimum = MIN_W'(tie.ratio);
        end
        default: minimum = MIN_AT_RESET;
      endcase
      write_minimum(minimum);
      if (ph == 2 || ph == 7) long_hold_req = 1'b1;
      send_pair(lead);
      repeat (RANDOM_PER_PHASE) send_pair(random_pair());
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
